// ===== src/rrrs_pkg.sv =====
// shared constants and control types of the resend ring scheduler
`timescale 1ns / 1ps

package rrrs_pkg;

  localparam int unsigned RING_SLOTS_DEF = 32;
  localparam int unsigned MAX_BYTES_DEF  = 1024;
  localparam int unsigned HDR_SLACK_BITS = 8;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SPACE_W    = 16;
  localparam int unsigned BITS_W     = 14;
  localparam int unsigned REF_W      = 16;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned SLOT_W     = 5;
  localparam int unsigned SENDS_W    = 3;
  localparam int unsigned SPACING_W  = 10;
  localparam int unsigned LEN_W      = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [KIND_W-1:0] KIND_STORE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESET = 2'd2;

  localparam logic [STATUS_W-1:0] ST_STORED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_LEN    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RESEND     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TICK_DONE  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RESET_DONE = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_RESEND_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REDUNDANCY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING_MS    = 2'd2;

  localparam logic                 RESEND_ENABLE_RST = 1'b1;
  localparam logic [SENDS_W-1:0]   REDUNDANCY_RST    = 3'd2;
  localparam logic [SPACING_W-1:0] SPACING_RST       = 10'd50;
  localparam logic [SPACING_W-1:0] SPACING_MIN       = 10'd10;
  localparam logic [SPACING_W-1:0] SPACING_MAX       = 10'd1000;

  typedef struct packed {
    logic capture;
    logic mem_re;
    logic do_store;
    logic do_resend;
    logic do_reset;
    logic do_done;
  } rrrs_cmd_t;

  typedef struct packed {
    logic hit;
    logic out_free;
    logic resend_enable;
  } rrrs_sts_t;

endpackage

// ===== src/rrrs_ctrl.sv =====
// controller state machine: item decode and slot walk sequencing
`timescale 1ns / 1ps

module rrrs_ctrl #(
  parameter int unsigned RING_SLOTS = rrrs_pkg::RING_SLOTS_DEF,
  localparam int unsigned IDX_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1,
  localparam int unsigned CNT_W = $clog2(RING_SLOTS + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [rrrs_pkg::KIND_W-1:0] kind_i,
  output logic                        in_stall_o,
  input  rrrs_pkg::rrrs_sts_t         sts_i,
  output rrrs_pkg::rrrs_cmd_t         cmd_o,
  output logic [IDX_W-1:0]            rd_addr_o,
  output logic [IDX_W-1:0]            ev_addr_o
);
  import rrrs_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_STORE     = 3'd1;
  localparam logic [2:0] S_RESET     = 3'd2;
  localparam logic [2:0] S_TICK_RUN  = 3'd3;
  localparam logic [2:0] S_TICK_DONE = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0] ev_idx_q, ev_idx_d;
  logic             ev_valid_q, ev_valid_d;
  logic             rd_more;
  logic             blocked;

  assign in_stall_o = (state_q != S_IDLE);
  assign rd_addr_o  = rd_idx_q[IDX_W-1:0];
  assign ev_addr_o  = ev_idx_q;
  assign rd_more    = (rd_idx_q < CNT_W'(RING_SLOTS));
  assign blocked    = ev_valid_q && sts_i.hit && !sts_i.out_free;

  always_comb begin
    state_d    = state_q;
    rd_idx_d   = rd_idx_q;
    ev_idx_d   = ev_idx_q;
    ev_valid_d = ev_valid_q;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (kind_i)
            KIND_STORE: state_d = S_STORE;
            KIND_RESET: state_d = S_RESET;
            KIND_TICK: begin
              rd_idx_d   = '0;
              ev_valid_d = 1'b0;
              state_d    = sts_i.resend_enable ? S_TICK_RUN : S_TICK_DONE;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_STORE: begin
        if (sts_i.out_free) begin
          cmd_o.do_store = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_RESET: begin
        if (sts_i.out_free) begin
          cmd_o.do_reset = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_TICK_RUN: begin
        if (!blocked) begin
          cmd_o.do_resend = ev_valid_q && sts_i.hit;
          cmd_o.mem_re    = rd_more;
          ev_valid_d      = rd_more;
          ev_idx_d        = rd_idx_q[IDX_W-1:0];
          if (rd_more) begin
            rd_idx_d = rd_idx_q + 1'b1;
          end else begin
            state_d = S_TICK_DONE;
          end
        end
      end
      S_TICK_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.do_done = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rd_idx_q   <= '0;
      ev_idx_q   <= '0;
      ev_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_idx_q   <= rd_idx_d;
      ev_idx_q   <= ev_idx_d;
      ev_valid_q <= ev_valid_d;
    end
  end

endmodule

// ===== src/rrrs_datapath.sv =====
// datapath: config registers, slot memory, pending bits, checks and result register
`timescale 1ns / 1ps

module rrrs_datapath #(
  parameter int unsigned RING_SLOTS = rrrs_pkg::RING_SLOTS_DEF,
  parameter int unsigned MAX_BYTES  = rrrs_pkg::MAX_BYTES_DEF,
  localparam int unsigned IDX_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rrrs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rrrs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [rrrs_pkg::TIME_W-1:0]     now_ms_i,
  input  logic [rrrs_pkg::SPACE_W-1:0]    tx_space_bits_i,
  input  logic [rrrs_pkg::BITS_W-1:0]     bit_count_i,
  input  logic [rrrs_pkg::REF_W-1:0]      payload_ref_i,
  input  rrrs_pkg::rrrs_cmd_t             cmd_i,
  input  logic [IDX_W-1:0]                rd_addr_i,
  input  logic [IDX_W-1:0]                ev_addr_i,
  output rrrs_pkg::rrrs_sts_t             sts_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rrrs_pkg::STATUS_W-1:0]   status_o,
  output logic [rrrs_pkg::REF_W-1:0]      sent_ref_o,
  output logic [rrrs_pkg::BITS_W-1:0]     sent_bits_o,
  output logic [rrrs_pkg::SLOT_W-1:0]     slot_index_o,
  output logic                            dropped_oldest_o,
  output logic [rrrs_pkg::SPACE_W-1:0]    space_left_o,
  output logic                            last_o
);
  import rrrs_pkg::*;

  localparam logic [LEN_W-1:0] MAX_BITS = LEN_W'(MAX_BYTES * 8);

  typedef struct packed {
    logic [REF_W-1:0]   pref;
    logic [BITS_W-1:0]  bits;
    logic [SENDS_W-1:0] sends;
    logic [TIME_W-1:0]  due;
  } slot_entry_t;

  slot_entry_t mem_q [RING_SLOTS];
  slot_entry_t rd_q;
  slot_entry_t wentry;
  logic             mem_we;
  logic [IDX_W-1:0] waddr;

  logic                 enable_q;
  logic [SENDS_W-1:0]   redundancy_q;
  logic [SPACING_W-1:0] spacing_q;

  logic [TIME_W-1:0]  now_q;
  logic [SPACE_W-1:0] space_q;
  logic [BITS_W-1:0]  bits_q;
  logic [REF_W-1:0]   ref_q;

  logic [RING_SLOTS-1:0] pending_q;
  logic [IDX_W-1:0]      head_q;
  logic [IDX_W-1:0]      head_next;

  logic [SPACING_W-1:0] eff_spacing;
  logic [TIME_W:0]      due_sum;
  logic [TIME_W-1:0]    due_new;
  logic [LEN_W-1:0]     bits_ext, rd_bits_ext, space_ext;
  logic                 bad_len, no_space, store_commit;
  logic [SENDS_W-1:0]   sends_dec;
  logic                 out_free, load;

  logic                 out_valid_q;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic [REF_W-1:0]     sent_ref_q, sent_ref_d;
  logic [BITS_W-1:0]    sent_bits_q, sent_bits_d;
  logic [SLOT_W-1:0]    slot_index_q, slot_index_d;
  logic                 dropped_q, dropped_d;
  logic [SPACE_W-1:0]   space_left_q, space_left_d;
  logic                 last_q, last_d;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= RESEND_ENABLE_RST;
      redundancy_q <= REDUNDANCY_RST;
      spacing_q    <= SPACING_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RESEND_ENABLE: enable_q     <= cfg_wdata_i[0];
        CFG_REDUNDANCY:    redundancy_q <= cfg_wdata_i[SENDS_W-1:0];
        CFG_SPACING_MS:    spacing_q    <= cfg_wdata_i[SPACING_W-1:0];
        default: ;
      endcase
    end
  end

  // captured item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      now_q   <= now_ms_i;
      space_q <= tx_space_bits_i;
      bits_q  <= bit_count_i;
      ref_q   <= payload_ref_i;
    end else if (cmd_i.do_resend) begin
      space_q <= space_q - SPACE_W'(rd_q.bits);
    end
  end

  // due time, saturating
  always_comb begin
    if (spacing_q < SPACING_MIN) begin
      eff_spacing = SPACING_MIN;
    end else if (spacing_q > SPACING_MAX) begin
      eff_spacing = SPACING_MAX;
    end else begin
      eff_spacing = spacing_q;
    end
    due_sum = {1'b0, now_q} + (TIME_W + 1)'(eff_spacing);
    due_new = due_sum[TIME_W] ? '1 : due_sum[TIME_W-1:0];
  end

  assign bits_ext     = LEN_W'(bits_q);
  assign rd_bits_ext  = LEN_W'(rd_q.bits);
  assign space_ext    = LEN_W'(space_q);
  assign bad_len      = (bits_q == '0) || (bits_ext > MAX_BITS);
  assign no_space     = space_ext < (bits_ext + LEN_W'(HDR_SLACK_BITS));
  assign store_commit = cmd_i.do_store && !bad_len && !no_space;
  assign sends_dec    = rd_q.sends - 1'b1;
  assign head_next    = (head_q == IDX_W'(RING_SLOTS - 1)) ? '0 : head_q + 1'b1;

  assign sts_o.hit = pending_q[ev_addr_i] && (now_q >= rd_q.due) && (rd_q.bits != '0)
                     && (rd_bits_ext <= MAX_BITS)
                     && (space_ext >= rd_bits_ext + LEN_W'(HDR_SLACK_BITS));
  assign sts_o.out_free      = out_free;
  assign sts_o.resend_enable = enable_q;

  // pending bits and ring head
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      head_q    <= '0;
    end else if (cmd_i.do_reset) begin
      pending_q <= '0;
      head_q    <= '0;
    end else if (store_commit) begin
      pending_q[head_q] <= (redundancy_q != '0);
      head_q            <= head_next;
    end else if (cmd_i.do_resend) begin
      pending_q[ev_addr_i] <= (sends_dec != '0);
    end
  end

  // slot memory
  always_comb begin
    mem_we = store_commit || cmd_i.do_resend;
    if (cmd_i.do_store) begin
      waddr        = head_q;
      wentry.pref  = ref_q;
      wentry.bits  = bits_q;
      wentry.sends = redundancy_q;
    end else begin
      waddr        = ev_addr_i;
      wentry.pref  = rd_q.pref;
      wentry.bits  = rd_q.bits;
      wentry.sends = sends_dec;
    end
    wentry.due = due_new;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wentry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_re) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // result register
  assign out_free = !out_valid_q || !out_stall_i;
  assign load     = cmd_i.do_store || cmd_i.do_resend || cmd_i.do_reset || cmd_i.do_done;

  always_comb begin
    status_d     = ST_TICK_DONE;
    sent_ref_d   = '0;
    sent_bits_d  = '0;
    slot_index_d = '0;
    dropped_d    = 1'b0;
    space_left_d = space_q;
    last_d       = 1'b1;
    if (cmd_i.do_store) begin
      if (bad_len) begin
        status_d = ST_BAD_LEN;
      end else if (no_space) begin
        status_d = ST_NO_SPACE;
      end else begin
        status_d     = ST_STORED;
        sent_ref_d   = ref_q;
        sent_bits_d  = bits_q;
        slot_index_d = SLOT_W'(head_q);
        dropped_d    = pending_q[head_q];
        space_left_d = space_q - SPACE_W'(bits_q);
      end
    end else if (cmd_i.do_resend) begin
      status_d     = ST_RESEND;
      sent_ref_d   = rd_q.pref;
      sent_bits_d  = rd_q.bits;
      slot_index_d = SLOT_W'(ev_addr_i);
      space_left_d = space_q - SPACE_W'(rd_q.bits);
      last_d       = 1'b0;
    end else if (cmd_i.do_reset) begin
      status_d = ST_RESET_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q     <= status_d;
      sent_ref_q   <= sent_ref_d;
      sent_bits_q  <= sent_bits_d;
      slot_index_q <= slot_index_d;
      dropped_q    <= dropped_d;
      space_left_q <= space_left_d;
      last_q       <= last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign sent_ref_o       = sent_ref_q;
  assign sent_bits_o      = sent_bits_q;
  assign slot_index_o     = slot_index_q;
  assign dropped_oldest_o = dropped_q;
  assign space_left_o     = space_left_q;
  assign last_o           = last_q;

endmodule

// ===== src/redundant_resend_ring_scheduler.sv =====
// top level of the resend ring scheduler: controller and datapath
// store, reset and disabled tick: one result, loaded from the STORE, RESET or TICK_DONE state
// enabled tick: one slot per cycle through the single read port of the slot memory, unless a
//   due resend waits on a stalled output; last result loaded from TICK_DONE after the walk
// output stalls hold the FSM; it takes the next item in idle, after the last result loads
// async reset clears config to defaults, ring head and pending bits; slot memory uncleared
`timescale 1ns / 1ps

module redundant_resend_ring_scheduler #(
  parameter int unsigned RING_SLOTS = rrrs_pkg::RING_SLOTS_DEF,
  parameter int unsigned MAX_BYTES  = rrrs_pkg::MAX_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rrrs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rrrs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [rrrs_pkg::KIND_W-1:0]     kind_i,
  input  logic [rrrs_pkg::TIME_W-1:0]     now_ms_i,
  input  logic [rrrs_pkg::SPACE_W-1:0]    tx_space_bits_i,
  input  logic [rrrs_pkg::BITS_W-1:0]     bit_count_i,
  input  logic [rrrs_pkg::REF_W-1:0]      payload_ref_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rrrs_pkg::STATUS_W-1:0]   status_o,
  output logic [rrrs_pkg::REF_W-1:0]      sent_ref_o,
  output logic [rrrs_pkg::BITS_W-1:0]     sent_bits_o,
  output logic [rrrs_pkg::SLOT_W-1:0]     slot_index_o,
  output logic                            dropped_oldest_o,
  output logic [rrrs_pkg::SPACE_W-1:0]    space_left_o,
  output logic                            last_o
);
  import rrrs_pkg::*;

  localparam int unsigned IDX_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;

  rrrs_cmd_t        cmd;
  rrrs_sts_t        sts;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] ev_addr;

  rrrs_ctrl #(
    .RING_SLOTS (RING_SLOTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr),
    .ev_addr_o  (ev_addr)
  );

  rrrs_datapath #(
    .RING_SLOTS (RING_SLOTS),
    .MAX_BYTES  (MAX_BYTES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .now_ms_i         (now_ms_i),
    .tx_space_bits_i  (tx_space_bits_i),
    .bit_count_i      (bit_count_i),
    .payload_ref_i    (payload_ref_i),
    .cmd_i            (cmd),
    .rd_addr_i        (rd_addr),
    .ev_addr_i        (ev_addr),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .sent_ref_o       (sent_ref_o),
    .sent_bits_o      (sent_bits_o),
    .slot_index_o     (slot_index_o),
    .dropped_oldest_o (dropped_oldest_o),
    .space_left_o     (space_left_o),
    .last_o           (last_o)
  );

endmodule
